>>> hw/rtl/lug_pkg.sv
// lug_pkg: shared widths, constants, state codes and control structs
// for the lfsr uniform integer generator
// no dependencies

package lug_pkg;

    localparam int SAMPLE_BITS_DEF = 10;

    localparam int LFSR_W  = 16;
    localparam int RANGE_W = 11;
    localparam int VALUE_W = 10;
    localparam int REM_W   = 12;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;

    localparam logic [LFSR_W-1:0]  FEEDBACK_MASK = 16'hB400;
    localparam logic [LFSR_W-1:0]  LFSR_RESET    = 16'h0001;
    localparam logic [RANGE_W-1:0] RANGE_RESET   = 11'd1024;

    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEED   = 4'b0010,
        ST_GATHER = 4'b0100,
        ST_CHECK  = 4'b1000
    } lug_state_t;

    typedef struct packed {
        logic seed_prep;
        logic seed_load;
        logic draw_init;
        logic gather_init;
        logic step;
        logic result_load;
    } lug_ctl_t;

    typedef struct packed {
        logic reject;
        logic out_full;
    } lug_status_t;

endpackage

>>> hw/rtl/lug_if.sv
// lug_if: valid/ready channel interfaces for input items and results
// depends on lug_pkg

interface lug_in_if;
    import lug_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;

    modport source (output valid, cmd, second, minute, hour, day, input ready);
    modport sink   (input valid, cmd, second, minute, hour, day, output ready);
endinterface

interface lug_out_if;
    import lug_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, value, input ready);
    modport sink   (input valid, value, output ready);
endinterface

>>> hw/rtl/lug_ctrl.sv
// lug_ctrl: sequencing state machine for seed and draw items
// depends on lug_pkg

module lug_ctrl #(
    parameter int SAMPLE_BITS = lug_pkg::SAMPLE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_cmd,
    output logic                 in_ready,
    input  lug_pkg::lug_status_t status,
    output lug_pkg::lug_ctl_t    ctl
);
    import lug_pkg::*;

    localparam int CNT_W = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_BITS - 1);

    lug_state_t       st_reg, st_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign in_ready = (st_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        ctl      = '0;
        unique case (st_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    if (in_cmd == CMD_SEED)
                    begin
                        ctl.seed_prep = 1'b1;
                        st_next       = ST_SEED;
                    end
                    else
                    begin
                        ctl.draw_init = 1'b1;
                        st_next       = ST_GATHER;
                    end
                end
            end
            ST_SEED:
            begin
                ctl.seed_load = 1'b1;
                st_next       = ST_IDLE;
            end
            ST_GATHER:
            begin
                ctl.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    st_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cnt_next = '0;
                if (status.reject)
                begin
                    // sample fell in the biased low band, draw again
                    ctl.gather_init = 1'b1;
                    st_next         = ST_GATHER;
                end
                else if (!status.out_full)
                begin
                    ctl.result_load = 1'b1;
                    st_next         = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_gather_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_GATHER && cnt_reg == CNT_LAST) |=> st_reg == ST_CHECK)
        else $error("gather did not end after the last bit");

    a_check_done: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_CHECK && !status.reject && !status.out_full) |=> st_reg == ST_IDLE)
        else $error("accepted sample did not finish the draw");
`endif

endmodule

>>> hw/rtl/lug_datapath.sv
// lug_datapath: lfsr, seed arithmetic, bit-serial remainders, result register
// depends on lug_pkg

module lug_datapath #(
    parameter int SAMPLE_BITS = lug_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lug_pkg::lug_ctl_t             ctl,
    output lug_pkg::lug_status_t          status,
    input  logic                          cfg_we,
    input  logic [lug_pkg::RANGE_W-1:0]   cfg_wdata,
    input  logic [lug_pkg::SEC_W-1:0]     second,
    input  logic [lug_pkg::MIN_W-1:0]     minute,
    input  logic [lug_pkg::HOUR_W-1:0]    hour,
    input  logic [lug_pkg::DAY_W-1:0]     day,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [lug_pkg::VALUE_W-1:0]   value
);
    import lug_pkg::*;

    localparam int SPAN = 1 << SAMPLE_BITS;
    localparam int CW   = (SAMPLE_BITS > REM_W) ? SAMPLE_BITS : REM_W;

    logic [RANGE_W-1:0]     range_reg;
    logic [LFSR_W-1:0]      lfsr_reg, lfsr_next;
    logic [LFSR_W-1:0]      seed1_reg;
    logic [2:0]             secdiv_reg;
    logic [RANGE_W-1:0]     m_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [REM_W-1:0]       low_reg, low_next;
    logic                   out_valid_reg;
    logic [VALUE_W-1:0]     value_reg;

    logic [RANGE_W-1:0]     m_clamp, m_use;
    logic [9:0]             hd;
    logic [LFSR_W-1:0]      seed1, seed2;
    logic [13:0]            sec_prod;
    logic                   fb_bit;
    logic [REM_W-1:0]       rem_sh, low_sh, m_ext;

    // bound of zero acts as one, bound above the sample span saturates
    always_comb
    begin
        if (range_reg == '0)
            m_clamp = RANGE_W'(1);
        else if (17'(range_reg) > 17'(SPAN))
            m_clamp = RANGE_W'(SPAN);
        else
            m_clamp = range_reg;
    end

    assign m_use = ctl.draw_init ? m_clamp : m_reg;

    // seed first stage: minute + 60*(hour + 24*day), second/10 by reciprocal
    assign hd       = 10'(hour) + 10'(day) * 10'd24;
    assign seed1    = 16'(minute) + 16'(hd) * 16'd60;
    assign sec_prod = 14'(second) * 14'd205;
    assign seed2    = 16'(seed1_reg * 16'd60) + 16'(secdiv_reg);

    // one lfsr step, its output bit feeds the sample and the remainder recurrence
    assign fb_bit    = lfsr_reg[0];
    assign lfsr_next = (lfsr_reg >> 1) ^ (fb_bit ? FEEDBACK_MASK : '0);

    assign m_ext  = REM_W'(m_reg);
    assign rem_sh = {rem_reg[REM_W-2:0], fb_bit};
    assign low_sh = {low_reg[REM_W-2:0], 1'b0};
    assign rem_next = (rem_sh >= m_ext) ? rem_sh - m_ext : rem_sh;
    assign low_next = (low_sh >= m_ext) ? low_sh - m_ext : low_sh;

    assign status.reject   = CW'(sample_reg) < CW'(low_reg);
    assign status.out_full = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg     <= RANGE_RESET;
            lfsr_reg      <= LFSR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                range_reg <= cfg_wdata;
            if (ctl.seed_load)
                lfsr_reg <= (seed2 == '0) ? LFSR_RESET : seed2;
            else if (ctl.step)
                lfsr_reg <= lfsr_next;
            if (ctl.result_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.seed_prep)
        begin
            seed1_reg  <= seed1;
            secdiv_reg <= sec_prod[13:11];
        end
        if (ctl.draw_init)
            m_reg <= m_clamp;
        if (ctl.draw_init || ctl.gather_init)
        begin
            sample_reg <= '0;
            rem_reg    <= '0;
            // remainder of the leading one of the span
            low_reg    <= (m_use == RANGE_W'(1)) ? '0 : REM_W'(1);
        end
        else if (ctl.step)
        begin
            sample_reg <= {sample_reg[SAMPLE_BITS-2:0], fb_bit};
            rem_reg    <= rem_next;
            low_reg    <= low_next;
        end
        if (ctl.result_load)
            value_reg <= rem_reg[VALUE_W-1:0];
    end

`ifndef SYNTHESIS
    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("lfsr reached the all-zero state");

    a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |=> (rem_reg < m_ext) && (low_reg < m_ext))
        else $error("remainder not below the bound");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.result_load |=> out_valid_reg && (REM_W'(value_reg) < m_ext))
        else $error("result not below the bound");
`endif

endmodule

>>> hw/rtl/lfsr_uniform_int_generator_unit.sv
// channel   dir  payload                              handshake
// in_ch     in   cmd, second, minute, hour, day       valid/ready
// out_ch    out  value                                valid/ready
// cfg       in   cfg_wdata (range_max)                cfg_we, no wait
//
// one item in flight; in_ch.ready is high only while the sequencer is idle
// seed word: accept, then a load through the second seed stage
// draw word: one lfsr bit per cycle while gathering, the remainders by
// range_max built bit-serially alongside; the sample is drawn again
// while it lands below 2^SAMPLE_BITS mod range_max
// the result sits in an output register; a draw stalls in its check step
// only while that register still holds an untaken word
// reset: range_max = 1024, lfsr = 1, no result pending
// depends on lug_pkg, lug_if, lug_ctrl, lug_datapath

module lfsr_uniform_int_generator_unit #(
    parameter int SAMPLE_BITS = lug_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    lug_in_if.sink                      in_ch,
    lug_out_if.source                   out_ch,
    input  logic                        cfg_we,
    input  logic [lug_pkg::RANGE_W-1:0] cfg_wdata
);
    import lug_pkg::*;

    lug_ctl_t    ctl;
    lug_status_t status;

    lug_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_cmd   (in_ch.cmd),
        .in_ready (in_ch.ready),
        .status   (status),
        .ctl      (ctl)
    );

    lug_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .second    (in_ch.second),
        .minute    (in_ch.minute),
        .hour      (in_ch.hour),
        .day       (in_ch.day),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .value     (out_ch.value)
    );

endmodule

>>> tb/sv/tb_top.sv
// tb_top: self-checking bench for lfsr_uniform_int_generator_unit, with its own
// lfsr/rejection predictor, a queued word driver and a result monitor
// depends on lug_pkg, lug_if and the unit under test

`timescale 1ns / 100ps

module tb_top;
    import lug_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_STALL   = 400;
    localparam int SETTLE       = 8;
    localparam int WORDS_PER_SET = 86;

    typedef struct packed {
        logic              cmd;
        logic [SEC_W-1:0]  second;
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
        logic [DAY_W-1:0]  day;
    } gen_word_t;

    localparam int WORD_W = $bits(gen_word_t);

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [RANGE_W-1:0] cfg_wdata;

    lug_in_if  in_if ();
    lug_out_if out_if ();

    lfsr_uniform_int_generator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [LFSR_W-1:0]  lfsr_model;
    logic [RANGE_W-1:0] bound_model;

    gen_word_t          word_q[$];
    logic [VALUE_W-1:0] drawn_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int stall_req;
    int stall_ack;
    int stall_left;
    int fail_count;
    int cycles;

    int bound_list [12] = '{1024, 3, 683, 1, 1000, 0, 2047, 100, 1025, 512, 7, 0};
    int send_list  [3]  = '{37, 85, 0};
    int recv_list  [3]  = '{85, 37, 0};

    gen_word_t taken;

    function automatic logic [LFSR_W-1:0] seed_value(gen_word_t w);
        int unsigned s;
        s = int'(w.second) / 10
            + 60 * (int'(w.minute) + 60 * (int'(w.hour) + 24 * int'(w.day)));
        s = s & 32'hFFFF;
        if (s == 0)
            s = 1;
        return s[LFSR_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] draw_value();
        int unsigned span;
        int unsigned m;
        int unsigned low;
        int unsigned sample;
        logic        fb;
        span = 1 << SAMPLE_BITS_DEF;
        m = 32'(bound_model);
        if (m == 0)
            m = 1;
        if (m > span)
            m = span;
        low = span % m;
        do
        begin
            sample = 0;
            for (int k = 0; k < SAMPLE_BITS_DEF; k++)
            begin
                fb = lfsr_model[0];
                lfsr_model = lfsr_model >> 1;
                if (fb)
                    lfsr_model = lfsr_model ^ FEEDBACK_MASK;
                sample = (sample << 1) | fb;
            end
        end while (sample < low);
        return VALUE_W'(sample % m);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_if.valid   = 1'b0;
        in_if.cmd     = CMD_SEED;
        in_if.second  = '0;
        in_if.minute  = '0;
        in_if.hour    = '0;
        in_if.day     = '0;
        out_if.ready  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req     = 0;
        fail_count    = 0;
        cycles        = 0;
        lfsr_model    = LFSR_RESET;
        bound_model   = RANGE_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // driver: offers the head of word_q, pops it when taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_if.valid <= 1'b0;
        end
        else
        begin
            if (in_if.valid && in_if.ready)
            begin
                taken = word_q.pop_front();
                if (taken.cmd == CMD_DRAW)
                    drawn_q.push_back(draw_value());
                else
                    lfsr_model = seed_value(taken);
            end
            if (in_if.valid && !in_if.ready)
            begin
                // word still waiting, keep it on the bus
            end
            else if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_if.valid  <= 1'b1;
                in_if.cmd    <= word_q[0].cmd;
                in_if.second <= word_q[0].second;
                in_if.minute <= word_q[0].minute;
                in_if.hour   <= word_q[0].hour;
                in_if.day    <= word_q[0].day;
            end
            else
            begin
                in_if.valid <= 1'b0;
                {in_if.cmd, in_if.second, in_if.minute, in_if.hour, in_if.day}
                    <= WORD_W'($urandom);
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
            stall_ack  <= 0;
        end
        else if (stall_req != stall_ack)
        begin
            stall_left <= LONG_STALL;
            stall_ack  <= stall_req;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    // monitor: checks each taken result against the oldest drawn value
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (drawn_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result value=%0d", out_if.value);
                end
                else
                begin
                    logic [VALUE_W-1:0] want;
                    want = drawn_q.pop_front();
                    if (out_if.value !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("value mismatch: expected %0d actual %0d",
                                     want, out_if.value);
                    end
                end
            end
            if (stall_left != 0 || stall_req != stall_ack)
                out_if.ready <= 1'b0;
            else
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_word(logic cmd, int s, int m, int h, int d);
        gen_word_t w;
        w.cmd    = cmd;
        w.second = s[SEC_W-1:0];
        w.minute = m[MIN_W-1:0];
        w.hour   = h[HOUR_W-1:0];
        w.day    = d[DAY_W-1:0];
        word_q.push_back(w);
    endtask

    task automatic push_draw();
        push_word(CMD_DRAW, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (word_q.size() != 0 || in_if.valid || drawn_q.size() != 0)
            @(negedge clk);
        // a seed word can still be loading
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_bound(int v);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[RANGE_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        bound_model = v[RANGE_W-1:0];
        @(negedge clk);
    endtask

    initial
    begin
        int bound;
        @(posedge rst_n);
        @(negedge clk);

        // directed: reset state, seeds that fold to zero, field extremes
        send_idle_pct = send_list[0];
        recv_idle_pct = recv_list[0];
        push_draw();
        push_draw();
        push_word(CMD_SEED, 5, 4, 9, 11);
        push_draw();
        push_word(CMD_SEED, 45, 49, 0, 3);
        push_draw();
        push_word(CMD_SEED, 63, 63, 31, 31);
        push_draw();
        push_word(CMD_SEED, 59, 59, 23, 31);
        push_draw();
        push_word(CMD_SEED, 0, 0, 0, 0);
        push_draw();
        write_bound(1);
        push_draw();
        push_draw();
        write_bound(0);
        push_draw();
        push_draw();
        write_bound(2047);
        push_draw();
        push_draw();
        write_bound(1000);
        push_draw();
        push_draw();
        push_draw();
        write_bound(683);
        push_draw();
        push_draw();
        push_draw();

        // random: three idle profiles, four bounds each
        for (int p = 0; p < 3; p++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                bound = bound_list[p * 4 + k];
                if (p * 4 + k == 11)
                    bound = $urandom_range(0, 2047);
                write_bound(bound);
                send_idle_pct = send_list[p];
                recv_idle_pct = recv_list[p];
                if (p == 2 && k == 0)
                    stall_req++;
                for (int n = 0; n < WORDS_PER_SET; n++)
                begin
                    if ($urandom_range(99) < 85)
                        push_draw();
                    else if ($urandom_range(9) < 7)
                        push_word(CMD_SEED, $urandom_range(59), $urandom_range(59),
                                  $urandom_range(23), $urandom_range(1, 31));
                    else
                        push_word(CMD_SEED, $urandom, $urandom, $urandom, $urandom);
                end
            end
        end

        wait_idle();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && drawn_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/lug_pkg.sv
hw/rtl/lug_if.sv
hw/rtl/lug_ctrl.sv
hw/rtl/lug_datapath.sv
hw/rtl/lfsr_uniform_int_generator_unit.sv
tb/sv/tb_top.sv
